/* src/rrtp_pkg.sv */
// Package for the round-robin task picker.
// Holds request codes, sequencer state type and the result beat type.
// No dependencies.
package rrtp_pkg;

    localparam logic [1:0] REQ_REGISTER = 2'd0;
    localparam logic [1:0] REQ_RUN      = 2'd1;
    localparam logic [1:0] REQ_SLEEP    = 2'd2;

    localparam int HANDLE_W = 16;
    localparam int INDEX_W  = 3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REG,
        ST_RUN_SCAN,
        ST_RUN_READ,
        ST_SLP_RD,
        ST_SLP_CMP,
        ST_DONE
    } rrtp_state_t;

    typedef struct packed {
        logic                accepted;
        logic                task_valid;
        logic [INDEX_W-1:0]  task_index;
        logic [HANDLE_W-1:0] chosen_handle;
    } rrtp_result_t;

endpackage

/* src/rrtp_handle_ram.sv */
// Handle table storage for the round-robin task picker.
// One write port, one read port with registered read data. Uses rrtp_pkg.
module rrtp_handle_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [AW-1:0]                 waddr,
    input  logic [rrtp_pkg::HANDLE_W-1:0] wdata,
    input  logic                          re,
    input  logic [AW-1:0]                 raddr,
    output logic [rrtp_pkg::HANDLE_W-1:0] rdata
);
    import rrtp_pkg::*;

    logic [HANDLE_W-1:0] mem [DEPTH];
    logic [HANDLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/rrtp_ctrl.sv */
// Sequencer for the round-robin task picker: slot scan, asleep flags, counters.
// Drives the handle RAM and produces one result beat per request. Uses rrtp_pkg.
module rrtp_ctrl #(
    parameter int MAX_TASKS = 8,
    parameter int SLOT_W    = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic [1:0]                    req_type,
    input  logic [rrtp_pkg::HANDLE_W-1:0] task_handle,
    output logic                          req_stall,
    output logic                          res_valid,
    input  logic                          res_stall,
    output rrtp_pkg::rrtp_result_t        res,
    output logic                          ram_we,
    output logic [SLOT_W-1:0]             ram_waddr,
    output logic [rrtp_pkg::HANDLE_W-1:0] ram_wdata,
    output logic                          ram_re,
    output logic [SLOT_W-1:0]             ram_raddr,
    input  logic [rrtp_pkg::HANDLE_W-1:0] ram_rdata
);
    import rrtp_pkg::*;

    localparam int              CNT_W   = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);

    rrtp_state_t          state_reg;
    rrtp_state_t          state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [SLOT_W-1:0]    next_slot_reg;
    logic [MAX_TASKS-1:0] asleep_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [CNT_W-1:0]     iter_reg;
    logic [HANDLE_W-1:0]  hdl_reg;
    rrtp_result_t         res_reg;

    logic                 accept;
    logic                 full;
    logic                 start_empty;
    logic                 awake;
    logic                 hdl_match;
    logic [CNT_W-1:0]     slot_inc;
    logic [SLOT_W-1:0]    slot_follow;
    logic                 slot_last;
    logic [CNT_W-1:0]     iter_inc;
    logic                 iter_last;
    logic [SLOT_W-1:0]    count_slot;
    logic [SLOT_W+INDEX_W-1:0] slot_wide;

    assign accept      = req_valid && (state_reg == ST_IDLE);
    assign full        = (count_reg == MAX_CNT);
    assign start_empty = (count_reg == '0) || (CNT_W'(next_slot_reg) >= count_reg);
    assign awake       = !asleep_reg[slot_reg];
    assign hdl_match   = (ram_rdata == hdl_reg);
    assign slot_inc    = CNT_W'(slot_reg) + CNT_W'(1);
    // wrap to slot 0 past the last registered task
    assign slot_follow = (slot_inc < count_reg) ? slot_inc[SLOT_W-1:0] : '0;
    assign slot_last   = (slot_inc == count_reg);
    assign iter_inc    = iter_reg + CNT_W'(1);
    assign iter_last   = (iter_inc == count_reg);
    assign count_slot  = count_reg[SLOT_W-1:0];
    assign slot_wide   = {{INDEX_W{1'b0}}, slot_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_type)
                        REQ_REGISTER: state_next = ST_REG;
                        REQ_RUN:      state_next = start_empty ? ST_DONE : ST_RUN_SCAN;
                        REQ_SLEEP:    state_next = (count_reg == '0) ? ST_DONE : ST_SLP_RD;
                        default:      state_next = ST_DONE;
                    endcase
                end
            end
            ST_REG:      state_next = ST_DONE;
            ST_RUN_SCAN:
            begin
                if (awake)
                begin
                    state_next = ST_RUN_READ;
                end
                else if (iter_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RUN_READ: state_next = ST_DONE;
            ST_SLP_RD:   state_next = ST_SLP_CMP;
            ST_SLP_CMP:  state_next = slot_last ? ST_DONE : ST_SLP_RD;
            ST_DONE:
            begin
                if (!res_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        req_stall = (state_reg != ST_IDLE);
        res_valid = (state_reg == ST_DONE);
        res       = res_reg;
        ram_we    = (state_reg == ST_REG) && !full;
        ram_waddr = count_slot;
        ram_wdata = hdl_reg;
        ram_re    = ((state_reg == ST_RUN_SCAN) && awake) || (state_reg == ST_SLP_RD);
        ram_raddr = slot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            next_slot_reg <= '0;
            asleep_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_REG) && !full)
            begin
                count_reg              <= count_reg + CNT_W'(1);
                asleep_reg[count_slot] <= 1'b0;
            end
            if ((state_reg == ST_RUN_SCAN) && awake)
            begin
                next_slot_reg <= slot_follow;
            end
            if ((state_reg == ST_SLP_CMP) && hdl_match)
            begin
                asleep_reg[slot_reg] <= 1'b1;
            end
        end
    end

    // working registers, loaded on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hdl_reg          <= task_handle;
            slot_reg         <= (req_type == REQ_RUN) ? next_slot_reg : '0;
            iter_reg         <= '0;
            res_reg          <= '0;
            res_reg.accepted <= (req_type == REQ_SLEEP);
        end
        else
        begin
            unique case (state_reg)
                ST_REG:
                begin
                    res_reg.accepted <= !full;
                end
                ST_RUN_SCAN:
                begin
                    if (!awake)
                    begin
                        slot_reg <= slot_follow;
                        iter_reg <= iter_inc;
                    end
                end
                ST_RUN_READ:
                begin
                    res_reg.accepted      <= 1'b1;
                    res_reg.task_valid    <= 1'b1;
                    res_reg.task_index    <= slot_wide[INDEX_W-1:0];
                    res_reg.chosen_handle <= ram_rdata;
                end
                ST_SLP_CMP:
                begin
                    slot_reg <= slot_inc[SLOT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("task count above table size");

    a_next_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (CNT_W'(next_slot_reg) < count_reg))
        else $error("next slot outside registered tasks");

    a_chosen_awake: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN_SCAN) && awake |=> !asleep_reg[slot_reg])
        else $error("run picked a sleeping task");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_reg))
        else $error("result changed while stalled");

endmodule

/* src/round_robin_task_picker.sv */
// Round-robin task picker over a table of MAX_TASKS task handles: a request
// beat registers a handle, picks the next awake task, or puts matching tasks
// to sleep, and each request gives exactly one result beat. One request is
// worked at a time by a small sequencer around the handle RAM and a single
// compare/increment step. A register request writes the handle to the RAM
// unless the table is full; a run request checks one slot per cycle, then
// does one RAM read; a sleep request gives each slot a RAM read and a
// compare. An output register holds the result beat, so a new request can
// be taken while the previous result waits downstream.
// Depends on rrtp_pkg, rrtp_handle_ram and rrtp_ctrl.
module round_robin_task_picker #(
    parameter int MAX_TASKS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  logic [1:0]                           req_type,
    input  logic [rrtp_pkg::HANDLE_W-1:0]        task_handle,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output logic                                 accepted,
    output logic                                 task_valid,
    output logic [rrtp_pkg::INDEX_W-1:0]         task_index,
    output logic [rrtp_pkg::HANDLE_W-1:0]        chosen_handle
);
    import rrtp_pkg::*;

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    logic                res_valid;
    logic                res_stall;
    rrtp_result_t        res;
    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    logic [HANDLE_W-1:0] ram_wdata;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [HANDLE_W-1:0] ram_rdata;

    logic                rsp_valid_reg;
    rrtp_result_t        rsp_reg;

    rrtp_handle_ram #(
        .DEPTH (MAX_TASKS),
        .AW    (SLOT_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rrtp_ctrl #(
        .MAX_TASKS (MAX_TASKS),
        .SLOT_W    (SLOT_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_type    (req_type),
        .task_handle (task_handle),
        .req_stall   (req_stall),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    // output register is free when empty or being drained this cycle
    assign res_stall = rsp_valid_reg && rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && !res_stall)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && !res_stall)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign accepted      = rsp_reg.accepted;
    assign task_valid    = rsp_reg.task_valid;
    assign task_index    = rsp_reg.task_index;
    assign chosen_handle = rsp_reg.chosen_handle;

endmodule

/* dv/tb_round_robin_task_picker.sv */
// Testbench for round_robin_task_picker: directed and random request beats,
// each result beat checked against a task-table predictor kept in the bench.
// Depends on rrtp_pkg and the picker RTL.
module tb_round_robin_task_picker;
    import rrtp_pkg::*;

    localparam int TASK_SLOTS = 8;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    logic [1:0] req_type = REQ_REGISTER;
    logic [HANDLE_W-1:0] task_handle = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    logic accepted;
    logic task_valid;
    logic [INDEX_W-1:0] task_index;
    logic [HANDLE_W-1:0] chosen_handle;

    // bench copy of the task table
    int tbl_count = 0;
    int tbl_next = 0;
    logic [HANDLE_W-1:0] tbl_handle [TASK_SLOTS];
    bit tbl_asleep [TASK_SLOTS];

    rrtp_result_t pending_picks [$];
    int err_count = 0;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_arm = 0;
    int hold_seen = 0;
    int hold_left = 0;

    round_robin_task_picker #(.MAX_TASKS(TASK_SLOTS)) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req_type(req_type),
        .task_handle(task_handle),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .accepted(accepted),
        .task_valid(task_valid),
        .task_index(task_index),
        .chosen_handle(chosen_handle)
    );

    always #2 clk = ~clk;

    initial
    begin
        #4000000;
        $display("simulation failed");
        $finish;
    end

    function automatic int slot_after(input int slot);
        return (slot + 1 < tbl_count) ? slot + 1 : 0;
    endfunction

    function automatic rrtp_result_t predict_pick(input logic [1:0] kind,
                                                  input logic [HANDLE_W-1:0] handle);
        rrtp_result_t res;
        int slot;
        int i;
        res = '0;
        case (kind)
            REQ_REGISTER:
            begin
                if (tbl_count < TASK_SLOTS)
                begin
                    tbl_handle[tbl_count] = handle;
                    tbl_asleep[tbl_count] = 1'b0;
                    tbl_count++;
                    res.accepted = 1'b1;
                end
            end
            REQ_RUN:
            begin
                if (tbl_count > 0 && tbl_next < tbl_count)
                begin
                    slot = tbl_next;
                    for (i = 0; i < tbl_count && !res.task_valid; i++)
                    begin
                        if (!tbl_asleep[slot])
                        begin
                            res.accepted = 1'b1;
                            res.task_valid = 1'b1;
                            res.task_index = slot[INDEX_W-1:0];
                            res.chosen_handle = tbl_handle[slot];
                            tbl_next = slot_after(slot);
                        end
                        else
                            slot = slot_after(slot);
                    end
                end
            end
            REQ_SLEEP:
            begin
                for (i = 0; i < tbl_count; i++)
                    if (tbl_handle[i] == handle)
                        tbl_asleep[i] = 1'b1;
                res.accepted = 1'b1;
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    // Receiver side: random stall, or a counted hold-off when one is armed.
    always @(posedge clk)
    begin
        if (hold_arm != hold_seen)
        begin
            hold_seen <= hold_arm;
            hold_left <= 300;
            rsp_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else
            rsp_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Inputs only move at the rising edge, so the negedge view is what the next edge takes.
    always @(negedge clk)
    begin : rsp_check
        rrtp_result_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_picks.size() == 0)
            begin
                $error("result beat with no request outstanding");
                err_count++;
            end
            else
            begin
                want = pending_picks.pop_front();
                check_field("accepted", want.accepted, accepted);
                check_field("task_valid", want.task_valid, task_valid);
                check_field("task_index", want.task_index, task_index);
                check_field("chosen_handle", want.chosen_handle, chosen_handle);
            end
        end
    end

    // Called at a rising edge; returns at the edge that takes the beat.
    task automatic send_request(input logic [1:0] kind, input logic [HANDLE_W-1:0] handle);
        bit taken;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_valid <= 1'b0;
            req_type <= logic'($urandom) ? REQ_UNUSED : REQ_RUN;
            task_handle <= HANDLE_W'($urandom);
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_type <= kind;
        task_handle <= handle;
        do
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        while (!taken);
        pending_picks.push_back(predict_pick(kind, handle));
    endtask

    task automatic send_random_mix(input int count);
        int i;
        int roll;
        for (i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 60)
                send_request(REQ_RUN, HANDLE_W'($urandom));
            else if (roll < 80)
                send_request(REQ_SLEEP, HANDLE_W'($urandom));
            else if (roll < 92)
                send_request(REQ_REGISTER, HANDLE_W'($urandom));
            else
                send_request(REQ_UNUSED, HANDLE_W'($urandom));
        end
    endtask

    task automatic test_empty_table();
        send_request(REQ_RUN, 16'hFFFF);
        send_request(REQ_SLEEP, 16'hFFFF);
        send_request(REQ_UNUSED, 16'hFFFF);
    endtask

    task automatic test_fill_table();
        send_request(REQ_REGISTER, 16'h0000);
        send_request(REQ_RUN, 16'h0000);
        send_request(REQ_REGISTER, 16'hFFFF);
        send_request(REQ_REGISTER, 16'hA5A5);
        send_request(REQ_REGISTER, 16'h5A5A);
        send_request(REQ_REGISTER, 16'hA5A5);
        send_request(REQ_REGISTER, 16'h0001);
        send_request(REQ_REGISTER, 16'h8000);
        send_request(REQ_REGISTER, 16'h7FFE);
        // table is full now
        send_request(REQ_REGISTER, 16'h1234);
    endtask

    task automatic test_sleep_skip();
        send_request(REQ_RUN, 16'h0000);
        // duplicate handle: both copies go to sleep
        send_request(REQ_SLEEP, 16'hA5A5);
        send_request(REQ_RUN, 16'h0000);
        send_request(REQ_SLEEP, 16'h4321);
        send_request(REQ_RUN, 16'h0000);
        send_request(REQ_RUN, 16'h0000);
        send_request(REQ_RUN, 16'h0000);
    endtask

    task automatic test_random_phases();
        src_idle_pct = 14;
        sink_stall_pct = 86;
        send_random_mix(560);
        src_idle_pct = 86;
        sink_stall_pct = 14;
        send_random_mix(560);
        src_idle_pct = 0;
        sink_stall_pct = 0;
        send_random_mix(560);
    endtask

    task automatic test_backpressure();
        int i;
        src_idle_pct = 0;
        sink_stall_pct = 0;
        hold_arm <= hold_arm + 1;
        for (i = 0; i < 24; i++)
            send_request(i % 3 == 0 ? REQ_SLEEP : REQ_RUN, HANDLE_W'($urandom));
    endtask

    task automatic test_all_asleep();
        int i;
        int n;
        src_idle_pct = 20;
        sink_stall_pct = 30;
        for (i = 0; i < TASK_SLOTS; i++)
        begin
            send_request(REQ_SLEEP, tbl_handle[i]);
            for (n = $urandom_range(3); n > 0; n--)
                send_request(REQ_RUN, HANDLE_W'($urandom));
        end
        send_request(REQ_RUN, 16'h0000);
        send_request(REQ_RUN, 16'hFFFF);
        send_request(REQ_REGISTER, 16'hBEEF);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_empty_table();
        test_fill_table();
        test_sleep_skip();
        test_random_phases();
        test_backpressure();
        test_all_asleep();
        req_valid <= 1'b0;
        while (pending_picks.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
src/rrtp_pkg.sv
src/rrtp_handle_ram.sv
src/rrtp_ctrl.sv
src/round_robin_task_picker.sv
dv/tb_round_robin_task_picker.sv
